@@ rtl/wwm_pkg.sv @@
// package: shared types, codes and constants of the waveform window measure
`timescale 1ns / 1ps
package wwm_pkg;

    // measure modes
    localparam logic [2:0] MODE_MAX   = 3'd0;
    localparam logic [2:0] MODE_MIN   = 3'd1;
    localparam logic [2:0] MODE_PP    = 3'd2;
    localparam logic [2:0] MODE_AVG   = 3'd3;
    localparam logic [2:0] MODE_RMS   = 3'd4;
    localparam logic [2:0] MODE_WHEN  = 3'd5;
    localparam logic [2:0] MODE_DELAY = 3'd6;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_DATA   = 3'd1;
    localparam logic [2:0] ST_NO_CROSS  = 3'd2;
    localparam logic [2:0] ST_NO_TRIG   = 3'd3;
    localparam logic [2:0] ST_NO_TARGET = 3'd4;

    // register indexes
    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_WSTART  = 3'd1;
    localparam logic [2:0] CFG_WEND    = 3'd2;
    localparam logic [2:0] CFG_LEVEL_A = 3'd3;
    localparam logic [2:0] CFG_EDGE_A  = 3'd4;
    localparam logic [2:0] CFG_CROSS_N = 3'd5;
    localparam logic [2:0] CFG_LEVEL_B = 3'd6;
    localparam logic [2:0] CFG_EDGE_B  = 3'd7;

    // edge filter bits
    localparam int EDGE_RISE_BIT = 0;
    localparam int EDGE_FALL_BIT = 1;

    // queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // shared divider
    localparam int DIV_STEPS = 64;
    localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]         mode;
        logic [31:0]        wstart;
        logic [31:0]        wend;
        logic signed [15:0] level_a;
        logic [1:0]         edge_a;
        logic [15:0]        cross_n;
        logic signed [15:0] level_b;
        logic [1:0]         edge_b;
    } t_cfg;

    typedef struct packed {
        logic [31:0]        t;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic               win;
        logic               last;
    } t_item;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    typedef enum logic [4:0] {
        S_IDLE, S_MUL1, S_MUL2, S_ACC, S_DA, S_WA, S_PB, S_DB, S_WB, S_UPD,
        S_FIN, S_DF, S_WF, S_SQ, S_RSQ, S_OUT
    } t_state;

    // segment p -> c crosses level under edge filter e
    function automatic logic crosses(logic signed [15:0] p, logic signed [15:0] c,
                                     logic signed [15:0] lvl, logic [1:0] e);
        logic up;
        logic dn;
        logic ok;
        up = (p <= lvl) && (c > lvl);
        dn = (p >= lvl) && (c < lvl);
        ok = 1'b1;
        if (e[EDGE_RISE_BIT] && !up) ok = 1'b0;
        if (e[EDGE_FALL_BIT] && !dn) ok = 1'b0;
        return ok && (up || dn);
    endfunction

    // magnitude of x - y
    function automatic logic [16:0] absdiff(logic signed [15:0] x, logic signed [15:0] y);
        logic signed [16:0] d;
        d = {x[15], x} - {y[15], y};
        return d[16] ? 17'(-d) : 17'(d);
    endfunction

endpackage

@@ rtl/wwm_front.sv @@
// front: accepts items, applies the time window and queues them for the back
`timescale 1ns / 1ps
module wwm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [31:0]    i_sample_time,
    input  logic [15:0]    i_sample_a,
    input  logic [15:0]    i_sample_b,
    input  logic           i_last_sample,
    input  wwm_pkg::t_cfg  i_cfg,
    input  logic           i_pop,
    output logic           o_avail,
    output wwm_pkg::t_item o_head
);
    import wwm_pkg::*;

    t_item            r_q [QDEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QCW-1:0]   r_cnt;
    logic             w_acc;
    logic             w_push;
    logic             w_pop;
    logic             w_win;

    // window classification
    assign w_win  = (i_sample_time >= i_cfg.wstart) && (i_sample_time <= i_cfg.wend);
    assign o_stall = (r_cnt == QCW'(QDEPTH));
    assign w_acc  = i_valid && !o_stall;
    // items outside the window that close nothing are dropped here
    assign w_push = w_acc && (w_win || i_last_sample);
    assign o_avail = (r_cnt != '0);
    assign w_pop  = i_pop && o_avail;
    assign o_head = r_q[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{t: i_sample_time, a: i_sample_a, b: i_sample_b,
                           win: w_win, last: i_last_sample};
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCW'(w_push) - QCW'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCW'(QDEPTH)) else $error("queue count over depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != QCW'(QDEPTH) && r_cnt != '0) |-> (r_wr != r_rd))
        else $error("queue pointers disagree with count");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == QCW'(QDEPTH) && !w_pop) |=> (r_cnt == QCW'(QDEPTH)))
        else $error("queue count moved while full");
`endif
endmodule

@@ rtl/wwm_div.sv @@
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module wwm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wwm_pkg::t_div_req i_req,
    output wwm_pkg::t_div_rsp o_rsp
);
    import wwm_pkg::*;

    logic [63:0]       r_q;
    logic [32:0]       r_rem;
    logic [32:0]       r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [33:0]       w_t;
    logic              w_ge;

    assign w_t  = {r_rem, r_q[63]};
    assign w_ge = (w_t >= {1'b0, r_den});

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? 33'(w_t - {1'b0, r_den}) : w_t[32:0];
            r_q   <= {r_q[62:0], w_ge};
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp = '{done: r_done, quot: r_q};
endmodule

@@ rtl/wwm_back.sv @@
// back: per-item accumulation, crossing search and final measurement
`timescale 1ns / 1ps
module wwm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wwm_pkg::t_cfg     i_cfg,
    input  logic              i_avail,
    input  wwm_pkg::t_item    i_head,
    output logic              o_pop,
    output wwm_pkg::t_div_req o_div,
    input  wwm_pkg::t_div_rsp i_div,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [32:0]       o_result_value,
    output logic              o_result_ok,
    output logic [2:0]        o_status_code
);
    import wwm_pkg::*;

    t_state r_state;
    t_state n_state;

    // accumulated state
    logic               r_have_prev;
    logic [31:0]        r_prev_t;
    logic signed [15:0] r_prev_a;
    logic signed [15:0] r_prev_b;
    logic signed [15:0] r_max;
    logic signed [15:0] r_min;
    logic signed [63:0] r_area;
    logic [63:0]        r_sq;
    logic [31:0]        r_span;
    logic [15:0]        r_mcount;
    logic               r_a_found;
    logic [31:0]        r_a_t;
    logic               r_b_found;
    logic [31:0]        r_b_t;

    // current item and segment terms
    t_item              r_c;
    logic [31:0]        r_dt;
    logic signed [16:0] r_sa;
    logic [31:0]        r_sqs;
    logic signed [49:0] r_term;
    logic [63:0]        r_sqp;
    logic               r_xa;
    logic               r_xb;
    logic               r_hitb;
    logic [16:0]        r_una;
    logic [16:0]        r_uda;
    logic [16:0]        r_unb;
    logic [16:0]        r_udb;

    // divider operands and final result
    logic [63:0]        r_num;
    logic [32:0]        r_den;
    logic               r_neg;
    logic [63:0]        r_sx;
    logic [63:0]        r_sr;
    logic [63:0]        r_sbit;
    logic signed [32:0] r_value;
    logic [2:0]         r_status;

    // output register
    logic               r_ov;
    logic signed [32:0] r_ov_value;
    logic [2:0]         r_ov_status;

    logic [31:0]        w_dt;
    logic signed [31:0] w_aa;
    logic signed [31:0] w_pp;
    logic signed [64:0] w_area;
    logic [64:0]        w_sq;
    logic [32:0]        w_span;
    logic [15:0]        w_minc;
    logic [15:0]        w_want;
    logic               w_hita;
    logic [63:0]        w_rb;
    logic               w_sq_ge;
    logic               w_load_out;

    // segment arithmetic
    assign w_dt   = (r_c.t >= r_prev_t) ? r_c.t - r_prev_t : '0;
    assign w_aa   = r_c.a * r_c.a;
    assign w_pp   = r_prev_a * r_prev_a;
    assign w_area = {r_area[63], r_area} + 65'(r_term);
    assign w_sq   = {1'b0, r_sq} + {1'b0, r_sqp};
    assign w_span = {1'b0, r_span} + {1'b0, r_dt};
    assign w_minc = (r_mcount != 16'hFFFF) ? r_mcount + 1'b1 : r_mcount;
    assign w_want = (i_cfg.mode == MODE_DELAY) ? 16'd1 : i_cfg.cross_n;
    assign w_hita = r_xa && !r_a_found && (w_minc == w_want);

    // integer square root step
    assign w_rb    = r_sr + r_sbit;
    assign w_sq_ge = (r_sx >= w_rb);

    assign w_load_out = (r_state == S_OUT) && !r_ov;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_avail) n_state = i_head.win ? S_MUL1 : S_FIN;
            end
            S_MUL1: n_state = r_have_prev ? S_MUL2 : S_UPD;
            S_MUL2: n_state = S_ACC;
            S_ACC:  n_state = w_hita ? S_DA : S_PB;
            S_DA:   n_state = (r_den == '0) ? S_PB : S_WA;
            S_WA: begin
                if (i_div.done) n_state = S_PB;
            end
            S_PB:   n_state = r_hitb ? S_DB : S_UPD;
            S_DB:   n_state = (r_den == '0) ? S_UPD : S_WB;
            S_WB: begin
                if (i_div.done) n_state = S_UPD;
            end
            S_UPD:  n_state = r_c.last ? S_FIN : S_IDLE;
            S_FIN: begin
                n_state = S_OUT;
                if (r_have_prev && r_span != '0 &&
                    (i_cfg.mode inside {MODE_AVG, MODE_RMS})) n_state = S_DF;
            end
            S_DF:   n_state = S_WF;
            S_WF: begin
                if (i_div.done) n_state = (i_cfg.mode == MODE_RMS) ? S_SQ : S_OUT;
            end
            S_SQ:   n_state = r_sbit[0] ? S_RSQ : S_SQ;
            S_RSQ:  n_state = S_OUT;
            S_OUT: begin
                if (!r_ov) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop = (r_state == S_IDLE) && i_avail;
        o_div = '{start: ((r_state == S_DA || r_state == S_DB) && r_den != '0) ||
                         (r_state == S_DF),
                  dividend: r_num, divisor: r_den};
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // accumulated state, cleared at reset and after each result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_load_out) begin
            r_have_prev <= 1'b0;
            r_prev_t    <= '0;
            r_prev_a    <= '0;
            r_prev_b    <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_area      <= '0;
            r_sq        <= '0;
            r_span      <= '0;
            r_mcount    <= '0;
            r_a_found   <= 1'b0;
            r_a_t       <= '0;
            r_b_found   <= 1'b0;
            r_b_t       <= '0;
        end else begin
            case (r_state)
                S_MUL1: begin
                    if (!r_have_prev) begin
                        r_max <= r_c.a;
                        r_min <= r_c.a;
                    end
                end
                S_ACC: begin
                    if (w_area[64] != w_area[63]) r_area <= w_area[64] ? S64_MIN : S64_MAX;
                    else                          r_area <= w_area[63:0];
                    r_sq   <= w_sq[64] ? '1 : w_sq[63:0];
                    r_span <= w_span[32] ? '1 : w_span[31:0];
                    if (r_c.a > r_max) r_max <= r_c.a;
                    if (r_c.a < r_min) r_min <= r_c.a;
                    if (r_xa) r_mcount <= w_minc;
                    if (w_hita) r_a_found <= 1'b1;
                    if (r_xb) r_b_found <= 1'b1;
                end
                S_DA: begin
                    if (r_den == '0) r_a_t <= r_prev_t;
                end
                S_WA: begin
                    if (i_div.done) r_a_t <= r_prev_t + i_div.quot[31:0];
                end
                S_DB: begin
                    if (r_den == '0) r_b_t <= r_prev_t;
                end
                S_WB: begin
                    if (i_div.done) r_b_t <= r_prev_t + i_div.quot[31:0];
                end
                S_UPD: begin
                    r_have_prev <= 1'b1;
                    r_prev_t    <= r_c.t;
                    r_prev_a    <= r_c.a;
                    r_prev_b    <= r_c.b;
                end
                default: ;
            endcase
        end
    end

    // item datapath, divider operands and final value
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_avail) r_c <= i_head;
            end
            S_MUL1: begin
                r_dt  <= w_dt;
                r_sa  <= {r_c.a[15], r_c.a} + {r_prev_a[15], r_prev_a};
                r_sqs <= 32'(w_aa) + 32'(w_pp);
                r_xa  <= crosses(r_prev_a, r_c.a, i_cfg.level_a, i_cfg.edge_a);
                r_xb  <= !r_b_found && crosses(r_prev_b, r_c.b, i_cfg.level_b, i_cfg.edge_b);
                r_una <= absdiff(i_cfg.level_a, r_prev_a);
                r_uda <= absdiff(r_c.a, r_prev_a);
                r_unb <= absdiff(i_cfg.level_b, r_prev_b);
                r_udb <= absdiff(r_c.b, r_prev_b);
            end
            S_MUL2: begin
                r_term <= r_sa * $signed({1'b0, r_dt});
                r_sqp  <= 64'(r_sqs) * 64'(r_dt);
            end
            S_ACC: begin
                r_hitb <= r_xb;
                r_num  <= 64'(r_una) * 64'(r_dt);
                r_den  <= 33'(r_uda);
            end
            S_PB: begin
                r_num <= 64'(r_unb) * 64'(r_dt);
                r_den <= 33'(r_udb);
            end
            S_FIN: begin
                r_num <= (i_cfg.mode == MODE_AVG) ?
                         (r_area[63] ? 64'(-r_area) : 64'(r_area)) : r_sq;
                r_den <= {r_span, 1'b0};
                r_neg <= r_area[63];
                if (i_cfg.mode <= MODE_RMS && !r_have_prev) begin
                    r_status <= ST_NO_DATA;
                    r_value  <= '0;
                end else begin
                    case (i_cfg.mode)
                        MODE_MAX: begin
                            r_status <= ST_OK;
                            r_value  <= 33'(r_max);
                        end
                        MODE_MIN: begin
                            r_status <= ST_OK;
                            r_value  <= 33'(r_min);
                        end
                        MODE_PP: begin
                            r_status <= ST_OK;
                            r_value  <= 33'(r_max) - 33'(r_min);
                        end
                        MODE_AVG, MODE_RMS: begin
                            r_status <= ST_OK;
                            r_value  <= '0;
                        end
                        MODE_WHEN: begin
                            r_status <= r_a_found ? ST_OK : ST_NO_CROSS;
                            r_value  <= r_a_found ? $signed({1'b0, r_a_t}) : '0;
                        end
                        MODE_DELAY: begin
                            if (!r_a_found) begin
                                r_status <= ST_NO_TRIG;
                                r_value  <= '0;
                            end else if (!r_b_found) begin
                                r_status <= ST_NO_TARGET;
                                r_value  <= '0;
                            end else begin
                                r_status <= ST_OK;
                                r_value  <= $signed({1'b0, r_b_t}) - $signed({1'b0, r_a_t});
                            end
                        end
                        default: begin
                            r_status <= ST_NO_DATA;
                            r_value  <= '0;
                        end
                    endcase
                end
            end
            S_WF: begin
                if (i_div.done) begin
                    r_value <= r_neg ? $signed(33'(-i_div.quot)) : $signed(i_div.quot[32:0]);
                    r_sx    <= i_div.quot;
                    r_sr    <= '0;
                    r_sbit  <= 64'h4000_0000_0000_0000;
                end
            end
            S_SQ: begin
                if (w_sq_ge) begin
                    r_sx <= r_sx - w_rb;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
            end
            S_RSQ: r_value <= $signed(r_sr[32:0]);
            default: ;
        endcase
    end

    // output register, parts the back from the result taker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (r_ov && !i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_ov_value  <= (r_status == ST_OK) ? r_value : '0;
            r_ov_status <= r_status;
        end
    end

    assign o_valid        = r_ov;
    assign o_result_value = r_ov_value;
    assign o_result_ok    = (r_ov_status == ST_OK);
    assign o_status_code  = r_ov_status;

`ifndef SYNTHESIS
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result_ok) |-> (o_result_value == '0))
        else $error("failed result carries a value");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div.start |=> (r_state == S_WA || r_state == S_WB || r_state == S_WF))
        else $error("divider started outside a wait sequence");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_MUL1 || r_state == S_FIN))
        else $error("item popped without being taken");
    a_sqrt_only_rms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |-> (i_cfg.mode == MODE_RMS))
        else $error("root step outside rms mode");
`endif
endmodule

@@ rtl/waveform_window_measure.sv @@
// top level: configuration registers, front queue, back sequencer, divider
//
// channel   direction  handshake           payload
// sample    in         i_valid / o_stall   i_sample_time, i_sample_a, i_sample_b, i_last_sample
// result    out        o_valid / i_stall   o_result_value, o_result_ok, o_status_code
// config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// an item in the window passes the back through S_MUL1, S_MUL2, S_ACC, S_PB and S_UPD
// (the first of a stream only S_MUL1 and S_UPD); one with a crossing of A or B waits on the
// shared 64-step divider; the closing item adds a divide for average or rms and a root for rms
// a 4-entry queue takes items while the back works; o_stall rises when it is full
// the result register holds one result under i_stall while the back goes on
// reset is synchronous and active low; it clears control, pointers, accumulators and config
`timescale 1ns / 1ps
module waveform_window_measure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_sample_time,
    input  logic [15:0] i_sample_a,
    input  logic [15:0] i_sample_b,
    input  logic        i_last_sample,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [32:0] o_result_value,
    output logic        o_result_ok,
    output logic [2:0]  o_status_code,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    import wwm_pkg::*;

    t_cfg     r_cfg;
    t_item    w_head;
    logic     w_avail;
    logic     w_pop;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mode: MODE_MAX, wstart: '0, wend: '1, level_a: '0, edge_a: '0,
                       cross_n: 16'd1, level_b: '0, edge_b: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MODE:    r_cfg.mode    <= i_cfg_data[2:0];
                CFG_WSTART:  r_cfg.wstart  <= i_cfg_data;
                CFG_WEND:    r_cfg.wend    <= i_cfg_data;
                CFG_LEVEL_A: r_cfg.level_a <= i_cfg_data[15:0];
                CFG_EDGE_A:  r_cfg.edge_a  <= i_cfg_data[1:0];
                CFG_CROSS_N: r_cfg.cross_n <= i_cfg_data[15:0];
                CFG_LEVEL_B: r_cfg.level_b <= i_cfg_data[15:0];
                CFG_EDGE_B:  r_cfg.edge_b  <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    wwm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_time (i_sample_time),
        .i_sample_a    (i_sample_a),
        .i_sample_b    (i_sample_b),
        .i_last_sample (i_last_sample),
        .i_cfg         (r_cfg),
        .i_pop         (w_pop),
        .o_avail       (w_avail),
        .o_head        (w_head)
    );

    wwm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    wwm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_avail        (w_avail),
        .i_head         (w_head),
        .o_pop          (w_pop),
        .o_div          (w_div_req),
        .i_div          (w_div_rsp),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_result_ok    (o_result_ok),
        .o_status_code  (o_status_code)
    );

`ifndef SYNTHESIS
    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_ok == (o_status_code == ST_OK)))
        else $error("ok flag disagrees with status");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status_code <= ST_NO_TARGET))
        else $error("status code out of range");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_result_value)))
        else $error("stalled result changed");
`endif
endmodule
